[sv/mmbh_pkg.sv]
// Package: payload structs, field widths and operation codes for the histogram unit.
`default_nettype none

package mmbh_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BINS_W     = 9;
    localparam int INDEX_W    = 8;
    localparam int OUT_CNT_W  = 32;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = SAMPLE_W + BINS_W;
    localparam int STEP_W     = 5;

    localparam logic [KIND_W-1:0] KIND_ACCUM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BINS       = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]  bin_index;
    } item_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] bin_count;
        logic [SAMPLE_W-1:0]  bin_low_edge;
        logic                 index_invalid;
    } result_t;

endpackage

`default_nettype wire

[sv/min_max_binned_histogram_unit.sv]
// Linear-bin intensity histogram: sequencer, shared multiplier/divider and count memory.
//
// Channels: item (valid/ready, mmbh_pkg::item_t) carries accumulate, read and clear
// operations; result (valid/ready, mmbh_pkg::result_t) returns one beat per read;
// cfg (valid/ready, always ready) writes range_low, range_high and bins_in_use.
// One item is worked at a time; item_ready is low while it is in flight.
// Accumulate: multiply, divider load, 9 divide steps, memory read, memory write;
//   a zero span skips to the memory read; the one-bit-per-cycle restoring divider bounds the rate.
// Read: multiply, divider load, 16 divide steps, memory read, result load; an invalid
//   index goes straight to the result load.
// Clear: every memory entry is zeroed, one entry per cycle.
// Reset: control and config registers take their reset values and a clearing pass
//   zeroes the count memory; item_ready stays low until it ends. cfg is taken
//   throughout.
// Stall: a finished result waits in the output register; a following read that
//   finishes before it is taken holds in its last step until the register frees.
`default_nettype none

module min_max_binned_histogram_unit #(
    parameter int MAX_BINS   = 256,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire mmbh_pkg::item_t                item,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output mmbh_pkg::result_t                   result,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mmbh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mmbh_pkg::SAMPLE_W-1:0]  cfg_data
);

    localparam int ADDR_W = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BINS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_CLR  = 3'd7;

    localparam int SW = mmbh_pkg::SAMPLE_W;
    localparam int BW = mmbh_pkg::BINS_W;
    localparam int PW = mmbh_pkg::PROD_W;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [ADDR_W-1:0]           clr_cnt_reg;
    logic                        result_valid_reg;

    logic [SW-1:0]               range_low_reg;
    logic [SW-1:0]               range_high_reg;
    logic [BW-1:0]               bins_reg;

    logic                        is_read_reg;
    logic                        invalid_reg;
    logic [SW-1:0]               mul_a_reg;
    logic [BW-1:0]               mul_b_reg;
    logic [PW-1:0]               prod_reg;
    logic [SW-1:0]               rem_reg;
    logic [PW-1:0]               dv_reg;
    logic [SW-1:0]               div_reg;
    logic [mmbh_pkg::STEP_W-1:0] steps_reg;
    logic [ADDR_W-1:0]           addr_reg;
    logic [SW-1:0]               edge_reg;
    logic [COUNT_BITS-1:0]       rd_data_reg;
    mmbh_pkg::result_t           result_reg;

    logic [COUNT_BITS-1:0]       mem [MAX_BINS];

    logic [BW-1:0]               bins_eff;
    logic [SW-1:0]               span;
    logic [SW-1:0]               sample_clamped;
    logic                        idx_bad;
    logic [SW:0]                 shifted;
    logic                        take_bit;
    logic [SW-1:0]               rem_step;
    logic [PW-1:0]               dv_step;
    logic [31:0]                 quot_ext;
    logic [31:0]                 idx_ext;
    logic [63:0]                 cnt_ext;
    logic                        item_fire;
    logic                        out_load;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [COUNT_BITS-1:0]       mem_wdata;

    assign item_ready   = (state_reg == S_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_load     = (state_reg == S_OUT) && (!result_valid_reg || result_ready);

    // bins_in_use of zero acts as one; values past the store size clamp to it
    always_comb
    begin
        if (bins_reg == '0)
            bins_eff = BW'(1);
        else if ({23'b0, bins_reg} > 32'(MAX_BINS))
            bins_eff = BW'(MAX_BINS);
        else
            bins_eff = bins_reg;
    end

    assign span = (range_high_reg > range_low_reg) ? (range_high_reg - range_low_reg) : '0;

    always_comb
    begin
        if (item.sample < range_low_reg)
            sample_clamped = range_low_reg;
        else if (item.sample > range_high_reg)
            sample_clamped = range_high_reg;
        else
            sample_clamped = item.sample;
    end

    assign idx_bad = ({1'b0, item.bin_index} >= bins_eff);
    assign idx_ext = {24'b0, item.bin_index};

    // one restoring divide step; quotient bits shift into the low end of dv
    assign shifted  = {rem_reg, dv_reg[PW-1]};
    assign take_bit = (shifted >= {1'b0, div_reg});
    assign rem_step = take_bit ? SW'(shifted - {1'b0, div_reg}) : shifted[SW-1:0];
    assign dv_step  = {dv_reg[PW-2:0], take_bit};
    assign quot_ext = {23'b0, dv_step[BW-1:0]};

    assign cnt_ext = {{(64-COUNT_BITS){1'b0}}, rd_data_reg};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (state_reg == S_CLR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if (state_reg == S_UPD)
        begin
            mem_we    = 1'b1;
            mem_wdata = (&rd_data_reg) ? rd_data_reg : (rd_data_reg + COUNT_BITS'(1));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    case (item.kind)
                        mmbh_pkg::KIND_ACCUM: state_next = (span == '0) ? S_RD : S_MUL;
                        mmbh_pkg::KIND_READ:  state_next = idx_bad ? S_OUT : S_MUL;
                        mmbh_pkg::KIND_CLEAR: state_next = S_CLR;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL:  state_next = S_LOAD;
            S_LOAD: state_next = S_DIV;
            S_DIV:
            begin
                if (steps_reg == mmbh_pkg::STEP_W'(1))
                    state_next = S_RD;
            end
            S_RD:   state_next = is_read_reg ? S_OUT : S_UPD;
            S_UPD:  state_next = S_IDLE;
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            S_CLR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
            range_low_reg    <= '0;
            range_high_reg   <= 16'hFFFF;
            bins_reg         <= 9'd256;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_CLR)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            else
                clr_cnt_reg <= '0;

            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mmbh_pkg::REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                    mmbh_pkg::REG_RANGE_HIGH: range_high_reg <= cfg_data;
                    mmbh_pkg::REG_BINS:       bins_reg       <= cfg_data[BW-1:0];
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    is_read_reg <= (item.kind == mmbh_pkg::KIND_READ);
                    invalid_reg <= idx_bad;
                    if (item.kind == mmbh_pkg::KIND_READ)
                    begin
                        mul_a_reg <= span;
                        mul_b_reg <= {1'b0, item.bin_index};
                        div_reg   <= {{(SW-BW){1'b0}}, bins_eff};
                        steps_reg <= mmbh_pkg::STEP_W'(SW);
                        addr_reg  <= idx_ext[ADDR_W-1:0];
                        edge_reg  <= '0;
                    end
                    else
                    begin
                        mul_a_reg <= sample_clamped - range_low_reg;
                        mul_b_reg <= bins_eff - BW'(1);
                        div_reg   <= span;
                        steps_reg <= mmbh_pkg::STEP_W'(BW);
                        addr_reg  <= '0;
                    end
                end
            end
            S_MUL:
            begin
                prod_reg <= {{BW{1'b0}}, mul_a_reg} * {{SW{1'b0}}, mul_b_reg};
            end
            S_LOAD:
            begin
                // quotient fits in steps_reg bits, so the top bits start below the divisor
                if (is_read_reg)
                begin
                    rem_reg <= {{(SW-BW){1'b0}}, prod_reg[PW-1:SW]};
                    dv_reg  <= {prod_reg[SW-1:0], {BW{1'b0}}};
                end
                else
                begin
                    rem_reg <= prod_reg[PW-1:BW];
                    dv_reg  <= {prod_reg[BW-1:0], {SW{1'b0}}};
                end
            end
            S_DIV:
            begin
                rem_reg   <= rem_step;
                dv_reg    <= dv_step;
                steps_reg <= steps_reg - mmbh_pkg::STEP_W'(1);
                if (steps_reg == mmbh_pkg::STEP_W'(1))
                begin
                    if (is_read_reg)
                        edge_reg <= range_low_reg + dv_step[SW-1:0];
                    else
                        addr_reg <= quot_ext[ADDR_W-1:0];
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    result_reg.bin_count     <= invalid_reg ? '0 : cnt_ext[31:0];
                    result_reg.bin_low_edge  <= edge_reg;
                    result_reg.index_invalid <= invalid_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == S_RD)
            rd_data_reg <= mem[addr_reg];
    end

endmodule

`default_nettype wire

[bench/tb_min_max_binned_histogram_unit.sv]
// Testbench for the histogram unit: directed and random item traffic checked against a predictor.
module tb_min_max_binned_histogram_unit;

    localparam int          MAX_BINS      = 256;
    localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;
    localparam int          DRAIN_CYCLES  = 300;     // covers a full clear pass
    localparam int          STALL_CYCLES  = 400;
    localparam int          RANDOM_PHASES = 12;
    localparam int          PHASE_ITEMS   = 150;
    localparam int          CYCLE_LIMIT   = 4000000;

    // kind code with no operation behind it
    localparam logic [mmbh_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           item_valid = 1'b0;
    logic                           item_ready;
    mmbh_pkg::item_t                item_bus = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    mmbh_pkg::result_t              result_bus;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mmbh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mmbh_pkg::SAMPLE_W-1:0]  cfg_data = '0;

    // predictor state
    logic [mmbh_pkg::SAMPLE_W-1:0]  cfg_low = 16'd0;
    logic [mmbh_pkg::SAMPLE_W-1:0]  cfg_high = 16'hFFFF;
    logic [mmbh_pkg::BINS_W-1:0]    cfg_bins = 9'd256;
    logic [31:0]                    bin_tally [MAX_BINS];
    mmbh_pkg::result_t              pending_reads [$];

    int  errors = 0;
    int  cycle_count = 0;
    int  stall_requests = 0;
    bit  idle_on = 1'b1;

    min_max_binned_histogram_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
    end

    function automatic longint unsigned eff_bins();
        if (cfg_bins == 0)
            return 1;
        if (cfg_bins > MAX_BINS)
            return MAX_BINS;
        return cfg_bins;
    endfunction

    function automatic longint unsigned range_span();
        longint unsigned s;
        s = 0;
        if (cfg_high > cfg_low)
            s = cfg_high - cfg_low;
        return s;
    endfunction

    function automatic void histogram_apply(input mmbh_pkg::item_t it);
        longint unsigned   b;
        longint unsigned   span;
        longint unsigned   v;
        longint unsigned   slot;
        mmbh_pkg::result_t r;
        b    = eff_bins();
        span = range_span();
        case (it.kind)
            mmbh_pkg::KIND_ACCUM:
            begin
                v    = it.sample;
                slot = 0;
                if (span != 0)
                begin
                    if (v < cfg_low)
                        v = cfg_low;
                    if (v > cfg_high)
                        v = cfg_high;
                    slot = ((v - cfg_low) * (b - 1)) / span;
                end
                if (slot < b)
                begin
                    if (bin_tally[slot] != COUNT_MAX)
                        bin_tally[slot] = bin_tally[slot] + 1;
                end
            end
            mmbh_pkg::KIND_READ:
            begin
                if (it.bin_index >= b)
                begin
                    r.bin_count     = '0;
                    r.bin_low_edge  = '0;
                    r.index_invalid = 1'b1;
                end
                else
                begin
                    r.bin_count     = bin_tally[it.bin_index];
                    r.bin_low_edge  = 16'(cfg_low + (it.bin_index * span) / b);
                    r.index_invalid = 1'b0;
                end
                pending_reads.push_back(r);
            end
            mmbh_pkg::KIND_CLEAR:
            begin
                foreach (bin_tally[i]) bin_tally[i] = '0;
            end
            default: ;  // unused kind: no effect
        endcase
    endfunction

    function automatic mmbh_pkg::item_t mk_item(input logic [mmbh_pkg::KIND_W-1:0] kind,
                                                input logic [mmbh_pkg::SAMPLE_W-1:0] sample,
                                                input logic [mmbh_pkg::INDEX_W-1:0] idx);
        mmbh_pkg::item_t it;
        it.kind      = kind;
        it.sample    = sample;
        it.bin_index = idx;
        return it;
    endfunction

    // Mostly well-formed: samples inside the range, reads of bins in use.
    task automatic random_item(output mmbh_pkg::item_t it);
        int r;
        it.sample    = 16'($urandom);
        it.bin_index = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 62)
        begin
            it.kind = mmbh_pkg::KIND_ACCUM;
            if (range_span() != 0 && $urandom_range(0, 99) < 85)
                it.sample = 16'($urandom_range(cfg_high, cfg_low));
        end
        else if (r < 92)
        begin
            it.kind = mmbh_pkg::KIND_READ;
            if ($urandom_range(0, 99) < 70)
                it.bin_index = 8'($urandom_range(0, int'(eff_bins()) - 1));
        end
        else if (r < 94)
            it.kind = mmbh_pkg::KIND_CLEAR;
        else
            it.kind = KIND_UNUSED;
    endtask

    task automatic send_item(input mmbh_pkg::item_t it);
        int gap;
        gap = 0;
        if (idle_on)
        begin
            while ($urandom_range(0, 99) < 20)
                gap++;
            if ($urandom_range(0, 99) < 3)
                gap += $urandom_range(5, 40);
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_bus   <= it;
        @(posedge clk);
        while (item_ready !== 1'b1)
            @(posedge clk);
        histogram_apply(it);
    endtask

    // Stop offering items, wait for every read beat, then let the block go idle.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mmbh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mmbh_pkg::SAMPLE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        case (idx)
            mmbh_pkg::REG_RANGE_LOW:  cfg_low  = data;
            mmbh_pkg::REG_RANGE_HIGH: cfg_high = data;
            mmbh_pkg::REG_BINS:       cfg_bins = data[mmbh_pkg::BINS_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [mmbh_pkg::SAMPLE_W-1:0] lo,
                              input logic [mmbh_pkg::SAMPLE_W-1:0] hi,
                              input logic [mmbh_pkg::BINS_W-1:0] nb);
        write_reg(mmbh_pkg::REG_RANGE_LOW, lo);
        write_reg(mmbh_pkg::REG_RANGE_HIGH, hi);
        write_reg(mmbh_pkg::REG_BINS, {7'd0, nb});
    endtask

    task automatic check_read_beat(input mmbh_pkg::result_t got);
        mmbh_pkg::result_t want;
        if (pending_reads.size() == 0)
        begin
            $display("%0t: unexpected result beat: count %0d edge %0d invalid %0b",
                     $time, got.bin_count, got.bin_low_edge, got.index_invalid);
            errors++;
        end
        else
        begin
            want = pending_reads.pop_front();
            if (got.bin_count !== want.bin_count)
            begin
                $display("%0t: bin_count expected %0d actual %0d",
                         $time, want.bin_count, got.bin_count);
                errors++;
            end
            if (got.bin_low_edge !== want.bin_low_edge)
            begin
                $display("%0t: bin_low_edge expected %0d actual %0d",
                         $time, want.bin_low_edge, got.bin_low_edge);
                errors++;
            end
            if (got.index_invalid !== want.index_invalid)
            begin
                $display("%0t: index_invalid expected %0b actual %0b",
                         $time, want.index_invalid, got.index_invalid);
                errors++;
            end
        end
    endtask

    // Result side: check each beat, drive ready with random idling and long holds.
    initial
    begin : result_monitor
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_ready)
                check_read_beat(result_bus);
            if (stall_requests != served)
            begin
                served    = stall_requests;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= !(idle_on && $urandom_range(0, 99) < 20);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("min_max_binned_histogram_unit test failed");
        $finish;
    end

    task automatic test_reset_defaults();
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd255));
        send_item(mk_item(KIND_UNUSED, 16'hFFFF, 8'hFF));
        settle();
    endtask

    task automatic test_full_range_extremes();
        set_config(16'd0, 16'hFFFF, 9'd256);
        send_item(mk_item(mmbh_pkg::KIND_ACCUM, 16'd0, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_ACCUM, 16'hFFFF, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_ACCUM, 16'h8000, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd255));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd127));
        settle();
    endtask

    task automatic test_clamping();
        set_config(16'd1000, 16'd2000, 9'd10);
        send_item(mk_item(mmbh_pkg::KIND_ACCUM, 16'd0, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_ACCUM, 16'hFFFF, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd9));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd10));  // first index past the bins in use
        settle();
    endtask

    task automatic test_degenerate_range();
        set_config(16'd500, 16'd500, 9'd16);
        send_item(mk_item(mmbh_pkg::KIND_ACCUM, 16'd7, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd15));
        settle();
        set_config(16'd600, 16'd100, 9'd16);             // inverted bounds
        send_item(mk_item(mmbh_pkg::KIND_ACCUM, 16'd300, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd0));
        settle();
    endtask

    task automatic test_bin_count_limits();
        set_config(16'd0, 16'hFFFF, 9'd0);               // zero bins acts as one
        send_item(mk_item(mmbh_pkg::KIND_ACCUM, 16'd40000, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd1));
        settle();
        write_reg(mmbh_pkg::REG_BINS, 16'd300);          // above the maximum
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd255));
        settle();
    endtask

    task automatic test_clear_and_unused();
        send_item(mk_item(mmbh_pkg::KIND_CLEAR, 16'd0, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd0));
        send_item(mk_item(KIND_UNUSED, 16'h1234, 8'd0));
        send_item(mk_item(mmbh_pkg::KIND_READ, 16'd0, 8'd0));
        settle();
    endtask

    task automatic test_random_traffic();
        mmbh_pkg::item_t               it;
        logic [mmbh_pkg::SAMPLE_W-1:0] lo;
        logic [mmbh_pkg::SAMPLE_W-1:0] hi;
        logic [mmbh_pkg::BINS_W-1:0]   nb;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_on = (p != 7);
            lo = 16'($urandom);
            hi = 16'($urandom);
            nb = 9'($urandom_range(1, MAX_BINS));
            case (p % 6)
                0:
                begin
                    lo = 16'd0;
                    hi = 16'hFFFF;
                    nb = 9'd256;
                end
                1:
                begin
                    lo = 16'($urandom_range(0, 65000));
                    hi = lo + 16'($urandom_range(1, 300));
                end
                3:
                begin
                    hi = 16'hFFFF;
                    nb = 9'($urandom_range(1, 2));
                end
                4: hi = lo - 16'($urandom_range(0, 1));  // equal or inverted bounds
                5:
                begin
                    lo = 16'd0;
                    hi = 16'hFFFF;
                end
                default: ;
            endcase
            set_config(lo, hi, nb);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_item(it);
                send_item(it);
            end
            settle();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_result_backpressure();
        mmbh_pkg::item_t it;
        idle_on = 1'b0;
        set_config(16'd0, 16'hFFFF, 9'd64);
        stall_requests++;
        for (int n = 0; n < 40; n++)
        begin
            random_item(it);
            it.kind = mmbh_pkg::KIND_READ;
            send_item(it);
        end
        settle();   // sender holds until every read beat is back
        for (int n = 0; n < 20; n++)
        begin
            random_item(it);
            send_item(it);
        end
        settle();
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_full_range_extremes();
        test_clamping();
        test_degenerate_range();
        test_bin_count_limits();
        test_clear_and_unused();
        test_random_traffic();
        test_result_backpressure();
        settle();
        if (errors == 0 && pending_reads.size() == 0)
            $display("min_max_binned_histogram_unit test passed");
        else
            $display("min_max_binned_histogram_unit test failed");
        $finish;
    end
endmodule

[filelist.f]
sv/mmbh_pkg.sv
sv/min_max_binned_histogram_unit.sv
bench/tb_min_max_binned_histogram_unit.sv
